### rtl/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg: shared types and sequencing table for the relative pose transform
// Job and result records, operand codes and the per-step micro-op table.
// ----------------------------------------------------------------------------
`default_nettype none

package rpt_pkg;

  localparam int QUAT_FRAC_BITS = 30;
  localparam int QUEUE_DEPTH    = 2;
  localparam int NUM_STEPS      = 52;
  localparam int STEP_W         = $clog2(NUM_STEPS);

  typedef struct packed {
    logic signed [31:0] bq_x;
    logic signed [31:0] bq_y;
    logic signed [31:0] bq_z;
    logic signed [31:0] bq_w;
    logic signed [31:0] tq_x;
    logic signed [31:0] tq_y;
    logic signed [31:0] tq_z;
    logic signed [31:0] tq_w;
    logic signed [48:0] d_x;
    logic signed [48:0] d_y;
    logic signed [48:0] d_z;
  } job_t;

  typedef struct packed {
    logic signed [47:0] p_x;
    logic signed [47:0] p_y;
    logic signed [47:0] p_z;
    logic signed [31:0] q_x;
    logic signed [31:0] q_y;
    logic signed [31:0] q_z;
    logic signed [31:0] q_w;
  } result_t;

  typedef enum logic [3:0] {
    OA_BX, OA_BY, OA_BZ, OA_BW,
    OA_M0, OA_M1, OA_M2, OA_M3, OA_M4, OA_M5, OA_M6, OA_M7, OA_M8
  } opa_t;

  typedef enum logic [3:0] {
    OB_BX, OB_BY, OB_BZ, OB_BW,
    OB_TX, OB_TY, OB_TZ, OB_TW,
    OB_DXL, OB_DYL, OB_DZL, OB_DXH, OB_DYH, OB_DZH
  } opb_t;

  typedef enum logic [4:0] {
    D_NONE,
    D_M0, D_M1, D_M2, D_M3, D_M4, D_M5, D_M6, D_M7, D_M8,
    D_QX, D_QY, D_QZ, D_QW,
    D_PX, D_PY, D_PZ
  } dst_t;

  typedef struct packed {
    opa_t a;
    opb_t b;
    logic neg;
    logic shl;
    logic clr;
    dst_t dst;
  } uop_t;

  function automatic uop_t mk(opa_t a, opb_t b, logic neg, logic shl, logic clr, dst_t dst);
    uop_t u;
    u.a   = a;
    u.b   = b;
    u.neg = neg;
    u.shl = shl;
    u.clr = clr;
    u.dst = dst;
    return u;
  endfunction

  // rotation matrix terms, relative quaternion, then the three rotated rows
  function automatic uop_t uop(logic [STEP_W-1:0] s);
    uop_t u;
    case (s)
      6'd0:  u = mk(OA_BY, OB_BY, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd1:  u = mk(OA_BZ, OB_BZ, 1'b0, 1'b0, 1'b0, D_M0);
      6'd2:  u = mk(OA_BX, OB_BY, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd3:  u = mk(OA_BZ, OB_BW, 1'b0, 1'b0, 1'b0, D_M1);
      6'd4:  u = mk(OA_BX, OB_BZ, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd5:  u = mk(OA_BY, OB_BW, 1'b1, 1'b0, 1'b0, D_M2);
      6'd6:  u = mk(OA_BX, OB_BY, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd7:  u = mk(OA_BZ, OB_BW, 1'b1, 1'b0, 1'b0, D_M3);
      6'd8:  u = mk(OA_BX, OB_BX, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd9:  u = mk(OA_BZ, OB_BZ, 1'b0, 1'b0, 1'b0, D_M4);
      6'd10: u = mk(OA_BY, OB_BZ, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd11: u = mk(OA_BX, OB_BW, 1'b0, 1'b0, 1'b0, D_M5);
      6'd12: u = mk(OA_BX, OB_BZ, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd13: u = mk(OA_BY, OB_BW, 1'b0, 1'b0, 1'b0, D_M6);
      6'd14: u = mk(OA_BY, OB_BZ, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd15: u = mk(OA_BX, OB_BW, 1'b1, 1'b0, 1'b0, D_M7);
      6'd16: u = mk(OA_BX, OB_BX, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd17: u = mk(OA_BY, OB_BY, 1'b0, 1'b0, 1'b0, D_M8);
      6'd18: u = mk(OA_BW, OB_TX, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd19: u = mk(OA_BX, OB_TW, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd20: u = mk(OA_BY, OB_TZ, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd21: u = mk(OA_BZ, OB_TY, 1'b0, 1'b0, 1'b0, D_QX);
      6'd22: u = mk(OA_BW, OB_TY, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd23: u = mk(OA_BX, OB_TZ, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd24: u = mk(OA_BY, OB_TW, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd25: u = mk(OA_BZ, OB_TX, 1'b1, 1'b0, 1'b0, D_QY);
      6'd26: u = mk(OA_BW, OB_TZ, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd27: u = mk(OA_BX, OB_TY, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd28: u = mk(OA_BY, OB_TX, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd29: u = mk(OA_BZ, OB_TW, 1'b1, 1'b0, 1'b0, D_QZ);
      6'd30: u = mk(OA_BW, OB_TW, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd31: u = mk(OA_BX, OB_TX, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd32: u = mk(OA_BY, OB_TY, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd33: u = mk(OA_BZ, OB_TZ, 1'b0, 1'b0, 1'b0, D_QW);
      6'd34: u = mk(OA_M0, OB_DXL, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd35: u = mk(OA_M0, OB_DXH, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd36: u = mk(OA_M1, OB_DYL, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd37: u = mk(OA_M1, OB_DYH, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd38: u = mk(OA_M2, OB_DZL, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd39: u = mk(OA_M2, OB_DZH, 1'b0, 1'b1, 1'b0, D_PX);
      6'd40: u = mk(OA_M3, OB_DXL, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd41: u = mk(OA_M3, OB_DXH, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd42: u = mk(OA_M4, OB_DYL, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd43: u = mk(OA_M4, OB_DYH, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd44: u = mk(OA_M5, OB_DZL, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd45: u = mk(OA_M5, OB_DZH, 1'b0, 1'b1, 1'b0, D_PY);
      6'd46: u = mk(OA_M6, OB_DXL, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd47: u = mk(OA_M6, OB_DXH, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd48: u = mk(OA_M7, OB_DYL, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd49: u = mk(OA_M7, OB_DYH, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd50: u = mk(OA_M8, OB_DZL, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd51: u = mk(OA_M8, OB_DZH, 1'b0, 1'b1, 1'b0, D_PZ);
      default: u = mk(OA_BX, OB_BX, 1'b0, 1'b0, 1'b1, D_NONE);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

### rtl/rpt_fifo.sv
// ----------------------------------------------------------------------------
// rpt_fifo: small register queue
// First-in first-out buffer with show-ahead output, DEPTH entries of W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

### rtl/rpt_front.sv
// ----------------------------------------------------------------------------
// rpt_front: pose intake
// Holds the latest target pose and issues a job for a base pose with a target
// pending, carrying the position difference and both quaternions.
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic                action,
  input  wire logic signed [47:0]  pos_x,
  input  wire logic signed [47:0]  pos_y,
  input  wire logic signed [47:0]  pos_z,
  input  wire logic signed [31:0]  quat_x,
  input  wire logic signed [31:0]  quat_y,
  input  wire logic signed [31:0]  quat_z,
  input  wire logic signed [31:0]  quat_w,
  output logic                     job_push,
  output rpt_pkg::job_t            job
);

  logic               pending_r, pending_nxt;
  logic signed [47:0] hp_x_r, hp_y_r, hp_z_r;
  logic signed [31:0] hq_x_r, hq_y_r, hq_z_r, hq_w_r;

  assign job_push = accept && !action && pending_r;

  always_comb begin
    pending_nxt = pending_r;
    if (accept) begin
      pending_nxt = action ? 1'b1 : 1'b0;
    end
  end

  always_comb begin
    job.bq_x = quat_x;
    job.bq_y = quat_y;
    job.bq_z = quat_z;
    job.bq_w = quat_w;
    job.tq_x = hq_x_r;
    job.tq_y = hq_y_r;
    job.tq_z = hq_z_r;
    job.tq_w = hq_w_r;
    job.d_x  = {hp_x_r[47], hp_x_r} - {pos_x[47], pos_x};
    job.d_y  = {hp_y_r[47], hp_y_r} - {pos_y[47], pos_y};
    job.d_z  = {hp_z_r[47], hp_z_r} - {pos_z[47], pos_z};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action) begin
      hp_x_r <= pos_x;
      hp_y_r <= pos_y;
      hp_z_r <= pos_z;
      hq_x_r <= quat_x;
      hq_y_r <= quat_y;
      hq_z_r <= quat_z;
      hq_w_r <= quat_w;
    end
  end

endmodule

`default_nettype wire

### rtl/rpt_back.sv
// ----------------------------------------------------------------------------
// rpt_back: transform engine
// Steps one shared multiplier and accumulator through the micro-op table,
// then rounds, saturates and hands the result record on.
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_back #(
  parameter int QUAT_FRAC_BITS = rpt_pkg::QUAT_FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_empty,
  input  wire rpt_pkg::job_t job,
  output logic               job_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output rpt_pkg::result_t   res
);

  localparam int M_W   = 68 - QUAT_FRAC_BITS;
  localparam int PW    = M_W + 33;
  localparam int ACC_W = M_W + 52;
  localparam int EW    = ACC_W + 2;
  localparam int SW    = rpt_pkg::STEP_W;

  localparam logic signed [EW-1:0] ONE_2Q = EW'(1) << (2 * QUAT_FRAC_BITS);
  localparam logic signed [EW-1:0] HALF   = EW'(1) << (QUAT_FRAC_BITS - 1);
  localparam logic signed [EW-1:0] P48MAX = (EW'(1) << 47) - EW'(1);
  localparam logic signed [EW-1:0] P48MIN = -P48MAX - EW'(1);
  localparam logic signed [EW-1:0] Q32MAX = (EW'(1) << 31) - EW'(1);
  localparam logic signed [EW-1:0] Q32MIN = -Q32MAX - EW'(1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_PUSH} state_t;

  state_t            state_r, state_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  rpt_pkg::job_t     job_r;
  rpt_pkg::uop_t     u;
  logic              issue;

  logic signed [M_W-1:0] m_r [9];
  logic signed [M_W-1:0] a_op;
  logic signed [32:0]    b_op;
  logic signed [PW-1:0]  prod_c, prod_r;
  logic                  s1_v_r, s1_neg_r, s1_shl_r, s1_clr_r;
  rpt_pkg::dst_t         s1_dst_r, s2_dst_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, prod_ext, term_sh, term;

  logic signed [EW-1:0] acc_ext, dbl, pre, rnd;
  logic                 diag, is_mat;
  logic signed [47:0]   sat48;
  logic signed [31:0]   sat32;

  assign issue = (state_r == ST_RUN);
  assign u     = rpt_pkg::uop(step_r);

  always_comb begin
    case (u.a)
      rpt_pkg::OA_BX: a_op = M_W'(job_r.bq_x);
      rpt_pkg::OA_BY: a_op = M_W'(job_r.bq_y);
      rpt_pkg::OA_BZ: a_op = M_W'(job_r.bq_z);
      rpt_pkg::OA_BW: a_op = M_W'(job_r.bq_w);
      rpt_pkg::OA_M0: a_op = m_r[0];
      rpt_pkg::OA_M1: a_op = m_r[1];
      rpt_pkg::OA_M2: a_op = m_r[2];
      rpt_pkg::OA_M3: a_op = m_r[3];
      rpt_pkg::OA_M4: a_op = m_r[4];
      rpt_pkg::OA_M5: a_op = m_r[5];
      rpt_pkg::OA_M6: a_op = m_r[6];
      rpt_pkg::OA_M7: a_op = m_r[7];
      rpt_pkg::OA_M8: a_op = m_r[8];
      default:        a_op = '0;
    endcase
    case (u.b)
      rpt_pkg::OB_BX:  b_op = 33'(job_r.bq_x);
      rpt_pkg::OB_BY:  b_op = 33'(job_r.bq_y);
      rpt_pkg::OB_BZ:  b_op = 33'(job_r.bq_z);
      rpt_pkg::OB_BW:  b_op = 33'(job_r.bq_w);
      rpt_pkg::OB_TX:  b_op = 33'(job_r.tq_x);
      rpt_pkg::OB_TY:  b_op = 33'(job_r.tq_y);
      rpt_pkg::OB_TZ:  b_op = 33'(job_r.tq_z);
      rpt_pkg::OB_TW:  b_op = 33'(job_r.tq_w);
      rpt_pkg::OB_DXL: b_op = {1'b0, job_r.d_x[31:0]};
      rpt_pkg::OB_DYL: b_op = {1'b0, job_r.d_y[31:0]};
      rpt_pkg::OB_DZL: b_op = {1'b0, job_r.d_z[31:0]};
      rpt_pkg::OB_DXH: b_op = 33'($signed(job_r.d_x[48:32]));
      rpt_pkg::OB_DYH: b_op = 33'($signed(job_r.d_y[48:32]));
      rpt_pkg::OB_DZH: b_op = 33'($signed(job_r.d_z[48:32]));
      default:         b_op = '0;
    endcase
  end

  assign prod_c = a_op * b_op;

  // accumulate
  always_comb begin
    prod_ext = ACC_W'(prod_r);
    term_sh  = s1_shl_r ? (prod_ext <<< 32) : prod_ext;
    term     = s1_neg_r ? -term_sh : term_sh;
    acc_nxt  = acc_r;
    if (s1_v_r) begin
      acc_nxt = (s1_clr_r ? '0 : acc_r) + term;
    end
  end

  // finalize: matrix terms are 1 - 2s or 2s, everything rounds half up
  always_comb begin
    diag    = (s2_dst_r == rpt_pkg::D_M0) || (s2_dst_r == rpt_pkg::D_M4) ||
              (s2_dst_r == rpt_pkg::D_M8);
    is_mat  = (s2_dst_r != rpt_pkg::D_NONE) && (s2_dst_r <= rpt_pkg::D_M8);
    acc_ext = EW'(acc_r);
    dbl     = acc_ext <<< 1;
    if (is_mat) begin
      pre = diag ? (ONE_2Q - dbl) : dbl;
    end else begin
      pre = acc_ext;
    end
    rnd = (pre + HALF) >>> QUAT_FRAC_BITS;
    if (rnd > P48MAX) begin
      sat48 = P48MAX[47:0];
    end else if (rnd < P48MIN) begin
      sat48 = P48MIN[47:0];
    end else begin
      sat48 = rnd[47:0];
    end
    if (rnd > Q32MAX) begin
      sat32 = Q32MAX[31:0];
    end else if (rnd < Q32MIN) begin
      sat32 = Q32MIN[31:0];
    end else begin
      sat32 = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_c;
    s1_neg_r <= u.neg;
    s1_shl_r <= u.shl;
    s1_clr_r <= u.clr;
    acc_r    <= acc_nxt;
    case (s2_dst_r)
      rpt_pkg::D_M0: m_r[0] <= rnd[M_W-1:0];
      rpt_pkg::D_M1: m_r[1] <= rnd[M_W-1:0];
      rpt_pkg::D_M2: m_r[2] <= rnd[M_W-1:0];
      rpt_pkg::D_M3: m_r[3] <= rnd[M_W-1:0];
      rpt_pkg::D_M4: m_r[4] <= rnd[M_W-1:0];
      rpt_pkg::D_M5: m_r[5] <= rnd[M_W-1:0];
      rpt_pkg::D_M6: m_r[6] <= rnd[M_W-1:0];
      rpt_pkg::D_M7: m_r[7] <= rnd[M_W-1:0];
      rpt_pkg::D_M8: m_r[8] <= rnd[M_W-1:0];
      rpt_pkg::D_QX: res.q_x <= sat32;
      rpt_pkg::D_QY: res.q_y <= sat32;
      rpt_pkg::D_QZ: res.q_z <= sat32;
      rpt_pkg::D_QW: res.q_w <= sat32;
      rpt_pkg::D_PX: res.p_x <= sat48;
      rpt_pkg::D_PY: res.p_y <= sat48;
      rpt_pkg::D_PZ: res.p_z <= sat48;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    job_pop   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!job_empty && !res_full) begin
          job_pop   = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(rpt_pkg::NUM_STEPS - 1)) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (s2_dst_r == rpt_pkg::D_PZ) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      res_push <= 1'b0;
      s1_v_r   <= 1'b0;
      s1_dst_r <= rpt_pkg::D_NONE;
      s2_dst_r <= rpt_pkg::D_NONE;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      res_push <= (state_nxt == ST_PUSH);
      s1_v_r   <= issue;
      s1_dst_r <= issue ? u.dst : rpt_pkg::D_NONE;
      s2_dst_r <= s1_v_r ? s1_dst_r : rpt_pkg::D_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
    end
  end

endmodule

`default_nettype wire

### rtl/relative_pose_transform.sv
// ----------------------------------------------------------------------------
// relative_pose_transform: relative pose of a held target seen from a base
// Target poses are held; a base pose with a target pending yields the rotated
// position difference and the relative quaternion.
// ----------------------------------------------------------------------------
//  channel  | ports                        | transaction
//  input    | push, full, in_*             | push && !full
//  result   | pop, empty, out_*            | pop && !empty
//
//  A target pose or an idle base pose is taken and gives nothing.
//  A base pose with a target pending runs 52 steps on one shared multiplier,
//  with the job take before them and pipeline drain and hand-off after; the
//  engine takes no new job until it has handed on the last result.
//  Jobs wait in a short queue, results in another; a held result stalls the
//  engine, then the job queue fills and full stalls the input.
//  Reset (rst_n low, synchronous) empties both queues and the pending flag.
// ----------------------------------------------------------------------------
`default_nettype none

module relative_pose_transform #(
  parameter int QUAT_FRAC_BITS = rpt_pkg::QUAT_FRAC_BITS,
  parameter int QUEUE_DEPTH    = rpt_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               in_action,
  input  wire logic signed [47:0] in_pos_x,
  input  wire logic signed [47:0] in_pos_y,
  input  wire logic signed [47:0] in_pos_z,
  input  wire logic signed [31:0] in_quat_x,
  input  wire logic signed [31:0] in_quat_y,
  input  wire logic signed [31:0] in_quat_z,
  input  wire logic signed [31:0] in_quat_w,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [47:0]      out_rel_pos_x,
  output logic signed [47:0]      out_rel_pos_y,
  output logic signed [47:0]      out_rel_pos_z,
  output logic signed [31:0]      out_rel_quat_x,
  output logic signed [31:0]      out_rel_quat_y,
  output logic signed [31:0]      out_rel_quat_z,
  output logic signed [31:0]      out_rel_quat_w
);

  localparam int JW = $bits(rpt_pkg::job_t);
  localparam int RW = $bits(rpt_pkg::result_t);

  logic             accept;
  logic             job_push, job_full, job_empty, job_pop;
  rpt_pkg::job_t    job_in, job_out;
  logic             res_push, res_full;
  rpt_pkg::result_t res_in, res_out;

  assign accept = push && !full;
  assign full   = job_full;

  rpt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .action   (in_action),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .pos_z    (in_pos_z),
    .quat_x   (in_quat_x),
    .quat_y   (in_quat_y),
    .quat_z   (in_quat_z),
    .quat_w   (in_quat_w),
    .job_push (job_push),
    .job      (job_in)
  );

  rpt_fifo #(.W(JW), .DEPTH(QUEUE_DEPTH)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  rpt_back #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  rpt_fifo #(.W(RW), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign out_rel_pos_x  = res_out.p_x;
  assign out_rel_pos_y  = res_out.p_y;
  assign out_rel_pos_z  = res_out.p_z;
  assign out_rel_quat_x = res_out.q_x;
  assign out_rel_quat_y = res_out.q_y;
  assign out_rel_quat_z = res_out.q_z;
  assign out_rel_quat_w = res_out.q_w;

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_job_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> !job_pop)
    else $error("engine took two jobs back to back");

endmodule

`default_nettype wire
